// ===== rtl/lds_pkg.sv =====
// shared types and constants for the loop detector
package lds_pkg;
	localparam int NumLoops = 4;
	localparam int PeriodBits = 16;
	localparam int DevScale = 10000;
	localparam logic [5:0] TimerMax = 6'd63;

	typedef enum logic [1:0] {
		REQ_MEAS  = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_START = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_QUIET  = 2'd1;
	localparam logic [1:0] REG_HOLD   = 2'd2;
	localparam logic [1:0] REG_ROUNDS = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load;     // take the input word, form the numerator
		logic div_init; // start the divider
		logic div_step; // one quotient bit
		logic cal_init; // start the calibration divide
		logic cal_step; // one calibration quotient bit
		logic finish;   // commit state and present result
	} lds_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic need_cal;
		logic div_last;
		logic cal_last;
	} lds_sts_t;
endpackage

// ===== rtl/loop_detector_scan_baseline.sv =====
// top level of the loop detector: config registers, controller and datapath
//  channel | dir | handshake           | payload
//  s_axis  | in  | tvalid/tready       | tuser: req_type; tdata: period_count, capture_ok
//  m_axis  | out | tvalid/tready       | tdata: loop_index, deviation, fault_flags,
//          |     |                     |        next_loop, calibrating
//  cfg     | in  | cfg_we              | cfg_index, cfg_data
// a valid measurement against a nonzero baseline outside calibration passes through a
// 31-step divide (ST_DIV), then ST_CALCHK and ST_DONE; other words go straight to ST_CALCHK;
// the measurement that closes calibration adds a 20-step divide per loop (ST_CAL).
// one word in flight; a new word is taken the cycle after the result has left.
// reset restores register defaults and clears all loop state.
module loop_detector_scan_baseline
	import lds_pkg::*;
#(
	parameter int NUM_LOOPS = NumLoops,
	parameter int PERIOD_BITS = PeriodBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,  // req_type
	input  logic [23:0] s_axis_tdata,  // period_count, capture_ok
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // loop_index, deviation, fault_flags, next_loop, calibrating
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	logic [3:0] en_q;
	logic [7:0] quiet_q;
	logic [5:0] hold_q;
	logic [3:0] rounds_q;
	lds_cmd_t   cmd;
	lds_sts_t   sts;
	logic [1:0]  r_idx, r_next;
	logic [15:0] r_dev;
	logic [3:0]  r_fault;
	logic        r_cal;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 4'd15;
			quiet_q <= 8'd3;
			hold_q <= 6'd30;
			rounds_q <= 4'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE: en_q <= cfg_data[3:0];
				REG_QUIET:  quiet_q <= cfg_data;
				REG_HOLD:   hold_q <= cfg_data[5:0];
				REG_ROUNDS: rounds_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	lds_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.sts(sts), .cmd(cmd)
	);

	lds_datapath #(.NUM_LOOPS(NUM_LOOPS), .PERIOD_BITS(PERIOD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(s_axis_tuser),
		.period_count(PERIOD_BITS'(s_axis_tdata[15:0])),
		.capture_ok(s_axis_tdata[16]),
		.loop_enable(en_q), .quiet_band(quiet_q),
		.drift_hold_seconds(hold_q), .cal_rounds(rounds_q),
		.res_loop_index(r_idx), .res_deviation(r_dev),
		.res_fault_flags(r_fault), .res_next_loop(r_next),
		.res_calibrating(r_cal)
	);

	assign m_axis_tdata = {7'd0, r_cal, r_next, r_fault, r_dev, r_idx};
endmodule

// ===== rtl/lds_datapath.sv =====
// detector state, serial divider and result assembly
module lds_datapath
	import lds_pkg::*;
#(
	parameter int NUM_LOOPS = NumLoops,
	parameter int PERIOD_BITS = PeriodBits
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lds_cmd_t               cmd,
	output lds_sts_t               sts,
	input  logic [1:0]             req_type,
	input  logic [PERIOD_BITS-1:0] period_count,
	input  logic                   capture_ok,
	input  logic [3:0]             loop_enable,
	input  logic [7:0]             quiet_band,
	input  logic [5:0]             drift_hold_seconds,
	input  logic [3:0]             cal_rounds,
	output logic [1:0]             res_loop_index,
	output logic [15:0]            res_deviation,
	output logic [3:0]             res_fault_flags,
	output logic [1:0]             res_next_loop,
	output logic                   res_calibrating
);
	localparam int IW = (NUM_LOOPS > 1) ? $clog2(NUM_LOOPS) : 1;
	localparam int SW = PERIOD_BITS + 4;
	localparam int NW = PERIOD_BITS + 15; // |numerator| < 2^PB * 2^14
	localparam int CW = $clog2(NW + 1);

	logic [PERIOD_BITS-1:0] baseline_q [NUM_LOOPS];
	logic [PERIOD_BITS-1:0] last_q     [NUM_LOOPS];
	logic [SW-1:0]          sum_q      [NUM_LOOPS];
	logic [5:0]             timer_q    [NUM_LOOPS];
	logic [NUM_LOOPS-1:0]   fault_q;
	logic [IW-1:0]          scan_q;
	logic [3:0]             round_q;
	logic [1:0]             meas_q;
	logic                   cal_q;

	// latched item
	logic [1:0]             req_q;
	logic [IW-1:0]          idx_q;
	logic                   neg_q;
	logic                   dev_zero_q;

	// restoring divider for the deviation
	logic [NW-1:0]          num_q;
	logic [PERIOD_BITS:0]   rem_q;
	logic [CW-1:0]          cnt_q;

	// calibration divider, one loop at a time
	logic [SW-1:0]          cnum_q;
	logic [4:0]             crem_q;
	logic [4:0]             ccnt_q;
	logic [IW-1:0]          cidx_q;

	logic [IW-1:0]          idx;
	logic [PERIOD_BITS-1:0] base_cur;
	logic [PERIOD_BITS:0]   diff;
	logic [PERIOD_BITS-1:0] diff_mag;
	logic [NW-1:0]          prod;
	logic [PERIOD_BITS+1:0] rem_try;
	logic [5:0]             crem_try;
	logic [NW-1:0]          qmag;
	logic [15:0]            dev;
	logic [15:0]            dev_mag;
	logic                   quiet;
	logic [IW-1:0]          next_scan;
	logic [1:0]             meas_nx;
	logic [3:0]             round_nx;
	logic [3:0]             need;
	logic                   round_end;
	logic                   rend_q;

	assign idx = scan_q;
	assign base_cur = baseline_q[idx];
	assign diff = {1'b0, base_cur} - {1'b0, period_count};
	assign diff_mag = diff[PERIOD_BITS] ? PERIOD_BITS'(-diff) : diff[PERIOD_BITS-1:0];
	assign prod = NW'(diff_mag) * NW'(DevScale);

	assign rem_try = {rem_q, num_q[NW-1]} - {2'b0, baseline_q[idx_q]};
	assign crem_try = {crem_q, cnum_q[SW-1]} - {2'b0, round_q};

	// saturate and sign the quotient
	always_comb begin
		qmag = num_q;
		if (dev_zero_q) begin
			dev = '0;
		end else if (neg_q) begin
			dev = (qmag > NW'(32768)) ? 16'h8000 : 16'(-qmag);
		end else begin
			dev = (qmag > NW'(32767)) ? 16'h7fff : qmag[15:0];
		end
		dev_mag = dev[15] ? 16'(-dev) : dev;
		quiet = dev_mag < {8'd0, quiet_band};
	end

	// round-robin search over enabled loops
	always_comb begin
		next_scan = IW'((32'(scan_q) + 1) % NUM_LOOPS);
		for (int k = NUM_LOOPS; k >= 1; k--) begin
			if (((32'(scan_q) + k) % NUM_LOOPS) < 4 &&
				loop_enable[2'((32'(scan_q) + k) % NUM_LOOPS)])
				next_scan = IW'((32'(scan_q) + k) % NUM_LOOPS);
		end
	end

	// calibration round bookkeeping
	always_comb begin
		meas_nx = meas_q + 2'd1;
		round_nx = round_q + 4'd1;
		need = (cal_rounds == 4'd0) ? 4'd1 : cal_rounds;
		round_end = (meas_q == 2'd3) && (round_nx >= need) && (round_nx != 4'd0);
	end

	assign sts.need_div = (req_type == REQ_MEAS) && capture_ok && !cal_q && (base_cur != '0);
	assign sts.need_cal = rend_q;
	assign sts.div_last = cnt_q == CW'(1);
	assign sts.cal_last = (ccnt_q == 5'd1) && (cidx_q == IW'(NUM_LOOPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LOOPS; i++) begin
				baseline_q[i] <= '0;
				last_q[i] <= '0;
				sum_q[i] <= '0;
				timer_q[i] <= '0;
			end
			fault_q <= '0;
			scan_q <= '0;
			round_q <= '0;
			meas_q <= '0;
			cal_q <= 1'b0;
			rend_q <= 1'b0;
			req_q <= '0;
			idx_q <= '0;
			neg_q <= 1'b0;
			dev_zero_q <= 1'b1;
			num_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			cnum_q <= '0;
			crem_q <= '0;
			ccnt_q <= '0;
			cidx_q <= '0;
			res_loop_index <= '0;
			res_deviation <= '0;
			res_fault_flags <= '0;
			res_next_loop <= '0;
			res_calibrating <= 1'b0;
		end else begin
			// take the item and apply the parts needing no division
			if (cmd.load) begin
				req_q <= req_type;
				idx_q <= idx;
				neg_q <= diff[PERIOD_BITS];
				dev_zero_q <= !sts.need_div;
				num_q <= prod;
				rem_q <= '0;
				rend_q <= 1'b0;
				unique case (req_type)
					REQ_MEAS: begin
						if (capture_ok) begin
							fault_q[idx] <= 1'b0;
							last_q[idx] <= period_count;
						end else begin
							fault_q[idx] <= 1'b1;
						end
						scan_q <= next_scan;
						if (cal_q) begin
							meas_q <= meas_nx;
							if (meas_q == 2'd3) begin
								round_q <= round_nx;
								for (int i = 0; i < NUM_LOOPS; i++)
									sum_q[i] <= sum_q[i] + SW'(capture_ok && IW'(i) == idx ?
										period_count : last_q[i]);
								rend_q <= round_end;
							end
						end
					end
					REQ_TICK: begin
						if (!cal_q) begin
							for (int i = 0; i < NUM_LOOPS; i++) begin
								if (timer_q[i] < TimerMax) begin
									timer_q[i] <= timer_q[i] + 6'd1;
								end
								if (((timer_q[i] < TimerMax) ? timer_q[i] + 6'd1 : timer_q[i])
									> drift_hold_seconds)
									baseline_q[i] <= PERIOD_BITS'(({1'b0, baseline_q[i]} +
										{1'b0, last_q[i]}) >> 1);
							end
						end
					end
					REQ_START: begin
						for (int i = 0; i < NUM_LOOPS; i++) begin
							baseline_q[i] <= '0;
							sum_q[i] <= '0;
						end
						round_q <= '0;
						meas_q <= '0;
						cal_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (cmd.div_init) begin
				cnt_q <= CW'(NW);
			end
			// one restoring step: quotient bits shift into num_q
			if (cmd.div_step) begin
				if (!rem_try[PERIOD_BITS+1]) begin
					rem_q <= rem_try[PERIOD_BITS:0];
					num_q <= {num_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[PERIOD_BITS-1:0], num_q[NW-1]};
					num_q <= {num_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.cal_init) begin
				cidx_q <= '0;
				cnum_q <= sum_q[0];
				crem_q <= '0;
				ccnt_q <= 5'(SW);
			end
			// calibration divide sum/round, loop by loop
			if (cmd.cal_step) begin
				if (!crem_try[5]) begin
					crem_q <= crem_try[4:0];
					cnum_q <= {cnum_q[SW-2:0], 1'b1};
				end else begin
					crem_q <= {crem_q[3:0], cnum_q[SW-1]};
					cnum_q <= {cnum_q[SW-2:0], 1'b0};
				end
				if (ccnt_q == 5'd1) begin
					baseline_q[cidx_q] <= PERIOD_BITS'({cnum_q[SW-2:0],
						!crem_try[5]});
					if (32'(cidx_q) < NUM_LOOPS - 1) begin
						cidx_q <= cidx_q + IW'(1);
						cnum_q <= sum_q[IW'(32'(cidx_q) + 1)];
						crem_q <= '0;
						ccnt_q <= 5'(SW);
					end else begin
						cal_q <= 1'b0;
					end
				end else begin
					ccnt_q <= ccnt_q - 5'd1;
				end
			end
			// result word and quiet-band timer clear
			if (cmd.finish) begin
				if (req_q == REQ_MEAS && quiet)
					timer_q[idx_q] <= '0;
				res_loop_index <= 2'(idx_q);
				res_deviation <= (req_q == REQ_MEAS) ? dev : 16'd0;
				res_fault_flags <= 4'(fault_q);
				res_next_loop <= 2'(scan_q);
				res_calibrating <= cal_q;
			end
		end
	end
endmodule

// ===== rtl/lds_ctrl.sv =====
// sequencing controller and output register handshake
module lds_ctrl
	import lds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  lds_sts_t sts,
	output lds_cmd_t cmd
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_CALCHK, ST_CAL, ST_DONE
	} state_t;

	state_t state_q;

	// a new word waits until the previous result has left
	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.div_init = cmd.load && sts.need_div;
		cmd.div_step = state_q == ST_DIV;
		cmd.cal_init = state_q == ST_CALCHK && sts.need_cal;
		cmd.cal_step = state_q == ST_CAL;
		cmd.finish = state_q == ST_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load)
						state_q <= sts.need_div ? ST_DIV : ST_CALCHK;
				end
				ST_DIV: begin
					if (sts.div_last)
						state_q <= ST_CALCHK;
				end
				ST_CALCHK: begin
					state_q <= sts.need_cal ? ST_CAL : ST_DONE;
				end
				ST_CAL: begin
					if (sts.cal_last)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== dv/loop_detector_scan_baseline_checker.sv =====
// checker for the loop detector: predicts each result word and compares it
module loop_detector_scan_baseline_checker
	import lds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,  // req_type
	input  logic [23:0] s_axis_tdata,  // period_count, capture_ok
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,  // loop_index, deviation, fault_flags, next_loop, calibrating
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        calibrating;
		logic [1:0]  next_loop;
		logic [3:0]  fault_flags;
		logic [15:0] deviation;
		logic [1:0]  loop_index;
	} scan_word_t;

	scan_word_t scan_results_due[$];

	// detector state mirror
	logic [3:0]  en_mask;
	logic [7:0]  quiet;
	logic [5:0]  hold;
	logic [3:0]  rounds;
	logic [15:0] base_q [4];
	logic [15:0] period_q [4];
	logic [19:0] sum_q [4];
	logic [5:0]  timer_q [4];
	logic [3:0]  faults;
	logic [1:0]  scan_pos;
	logic [3:0]  round_no;
	logic [1:0]  meas_in_round;
	logic        cal_on;

	assign pending = scan_results_due.size();

	function automatic logic signed [15:0] deviation_of(logic [15:0] b, logic [15:0] p);
		longint q;
		if (cal_on || b == 0) return 16'sd0;
		q = ((longint'(b) - longint'(p)) * DevScale) / longint'(b);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	task automatic scan_advance();
		logic [1:0] cand;
		for (int k = 1; k <= 4; k++) begin
			cand = scan_pos + k[1:0];
			if (en_mask[cand]) begin
				scan_pos = cand;
				return;
			end
		end
		scan_pos = scan_pos + 2'd1;
	endtask

	task automatic calibration_count();
		logic [3:0] need;
		meas_in_round = meas_in_round + 2'd1;
		if (meas_in_round != 0) return;
		for (int i = 0; i < 4; i++) sum_q[i] = sum_q[i] + 20'(period_q[i]);
		round_no = round_no + 4'd1;
		need = (rounds == 0) ? 4'd1 : rounds;
		if (round_no >= need && round_no != 0) begin
			for (int i = 0; i < 4; i++) base_q[i] = 16'(sum_q[i] / round_no);
			cal_on = 1'b0;
		end
	endtask

	task automatic predict_scan(logic [1:0] u, logic [23:0] w);
		req_t        req;
		logic [15:0] per;
		logic        ok;
		logic [1:0]  idx;
		logic signed [15:0] dev;
		int          mag;
		scan_word_t  r;
		req = req_t'(u);
		per = w[15:0];
		ok  = w[16];
		idx = scan_pos;
		dev = 0;
		case (req)
			REQ_MEAS: begin
				if (!ok) faults[idx] = 1'b1;
				else begin
					faults[idx] = 1'b0;
					period_q[idx] = per;
					dev = deviation_of(base_q[idx], per);
				end
				mag = (dev < 0) ? -int'(dev) : int'(dev);
				if (mag < int'(quiet)) timer_q[idx] = 0;
				scan_advance();
				if (cal_on) calibration_count();
			end
			REQ_TICK: begin
				if (!cal_on)
					for (int i = 0; i < 4; i++) begin
						if (timer_q[i] < TimerMax) timer_q[i] = timer_q[i] + 6'd1;
						if (timer_q[i] > hold)
							base_q[i] = 16'((17'(base_q[i]) + 17'(period_q[i])) >> 1);
					end
			end
			REQ_START: begin
				for (int i = 0; i < 4; i++) begin
					base_q[i] = 0;
					sum_q[i] = 0;
				end
				round_no = 0;
				meas_in_round = 0;
				cal_on = 1'b1;
			end
			default: ;
		endcase
		r.loop_index  = idx;
		r.deviation   = dev;
		r.fault_flags = faults;
		r.next_loop   = scan_pos;
		r.calibrating = cal_on;
		scan_results_due.push_back(r);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// mirror state, configuration and comparison
	always @(posedge clk or negedge arst_n) begin
		scan_word_t g, e;
		if (!arst_n) begin
			en_mask = 4'd15; quiet = 8'd3; hold = 6'd30; rounds = 4'd10;
			for (int i = 0; i < 4; i++) begin
				base_q[i] = 0; period_q[i] = 0; sum_q[i] = 0; timer_q[i] = 0;
			end
			faults = 0; scan_pos = 0; round_no = 0; meas_in_round = 0; cal_on = 0;
			fail_count = 0;
			scan_results_due.delete();
		end else begin
			if (cfg_we)
				case (cfg_index)
					REG_ENABLE: en_mask = cfg_data[3:0];
					REG_QUIET:  quiet = cfg_data;
					REG_HOLD:   hold = cfg_data[5:0];
					REG_ROUNDS: rounds = cfg_data[3:0];
					default: ;
				endcase
			if (m_axis_tvalid && m_axis_tready) begin
				g = m_axis_tdata[24:0];
				if (scan_results_due.size() == 0)
					report_mismatch("unexpected word", m_axis_tdata, 0);
				else begin
					e = scan_results_due.pop_front();
					if (g.loop_index != e.loop_index)
						report_mismatch("loop_index", g.loop_index, e.loop_index);
					if (g.deviation != e.deviation)
						report_mismatch("deviation", g.deviation, e.deviation);
					if (g.fault_flags != e.fault_flags)
						report_mismatch("fault_flags", g.fault_flags, e.fault_flags);
					if (g.next_loop != e.next_loop)
						report_mismatch("next_loop", g.next_loop, e.next_loop);
					if (g.calibrating != e.calibrating)
						report_mismatch("calibrating", g.calibrating, e.calibrating);
					if (m_axis_tdata[31:25] != 0)
						report_mismatch("pad bits", m_axis_tdata, 0);
				end
			end
			if (s_axis_tvalid && s_axis_tready) predict_scan(s_axis_tuser, s_axis_tdata);
		end
	end
endmodule

// ===== dv/loop_detector_scan_baseline_test.sv =====
// testbench top for the loop detector: stimulus, idling and verdict
module loop_detector_scan_baseline_test;
	import lds_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [1:0]  s_axis_tuser;  // req_type
	logic [23:0] s_axis_tdata;  // period_count, capture_ok
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;  // loop_index, deviation, fault_flags, next_loop, calibrating
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	int          fail_count;
	int          pending;
	logic        calm;
	int          idle_cycles;

	loop_detector_scan_baseline DUT (.*);

	loop_detector_scan_baseline_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// receiver stalls at random, except in calm stretches
	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 38);

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// valid stays high after a word is taken until the next gap or word
	task automatic send_word(req_t req, logic [15:0] per, logic ok);
		while (!calm && $urandom_range(99) < 38) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {7'd0, ok, per};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// period near a typical baseline, sometimes anywhere
	function automatic logic [15:0] pick_period();
		if ($urandom_range(9) < 7) return 16'(30000 + $urandom_range(400) - 200);
		return 16'($urandom);
	endfunction

	task automatic random_phase(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 70) send_word(REQ_MEAS, pick_period(), $urandom_range(15) != 0);
			else if (r < 92) send_word(REQ_TICK, 16'($urandom), 1'($urandom));
			else if (r < 97) send_word(REQ_START, 16'($urandom), 1'($urandom));
			else send_word(REQ_NONE, 16'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tuser = REQ_MEAS;
		s_axis_tdata = 0;
		m_axis_tready = 0;
		cfg_we = 0;
		cfg_index = REG_ENABLE;
		cfg_data = 0;
		calm = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero baseline, faults, extremes, calibration
		write_reg(REG_ROUNDS, 8'd1);
		send_word(REQ_MEAS, 16'hFFFF, 1'b1);
		send_word(REQ_MEAS, 16'h0000, 1'b0);
		send_word(REQ_NONE, 16'hFFFF, 1'b1);
		send_word(REQ_START, 16'h0, 1'b0);
		send_word(REQ_TICK, 16'h0, 1'b0);
		send_word(REQ_MEAS, 16'd1, 1'b1);
		send_word(REQ_MEAS, 16'hFFFF, 1'b1);
		send_word(REQ_MEAS, 16'd100, 1'b1);
		send_word(REQ_MEAS, 16'd5000, 1'b0);
		send_word(REQ_MEAS, 16'hFFFF, 1'b1);
		send_word(REQ_MEAS, 16'h0000, 1'b1);
		send_word(REQ_MEAS, 16'd1, 1'b1);
		send_word(REQ_MEAS, 16'd50, 1'b1);
		send_word(REQ_START, 16'h0, 1'b0);
		send_word(REQ_START, 16'h0, 1'b0);
		write_reg(REG_HOLD, 8'd0);
		write_reg(REG_QUIET, 8'd0);
		for (int k = 0; k < 8; k++) send_word(REQ_MEAS, 16'($urandom), 1'b1);
		send_word(REQ_TICK, 16'h0, 1'b0);
		for (int k = 0; k < 4; k++) send_word(REQ_MEAS, 16'($urandom), 1'b1);

		// random phases over several settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_ENABLE, (ph == 0) ? 8'd15 : (ph == 1) ? 8'd1 : 8'($urandom_range(1, 15)));
			write_reg(REG_QUIET, (ph == 2) ? 8'd255 : 8'($urandom_range(0, 40)));
			write_reg(REG_HOLD, (ph == 3) ? 8'd62 : 8'($urandom_range(0, 8)));
			write_reg(REG_ROUNDS, (ph == 4) ? 8'd15 : 8'($urandom_range(1, 4)));
			calm = (ph == 5);
			random_phase(120);
		end
		calm = 0;
		write_reg(REG_ENABLE, 8'd0);
		random_phase(20);

		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== loop_detector_scan_baseline.f =====
rtl/lds_pkg.sv
rtl/lds_datapath.sv
rtl/lds_ctrl.sv
rtl/loop_detector_scan_baseline.sv
dv/loop_detector_scan_baseline_checker.sv
dv/loop_detector_scan_baseline_test.sv
